/* hdl/mlc_pkg.sv */
// Shared types, constants and the outcode function of the midpoint line clipper.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package mlc_pkg;

	// Default sizes, handed to the top level parameters
	localparam int COORD_BITS_DEF = 16;
	localparam int MAX_STEPS_DEF  = 16;

	// Widest coordinate the outcode compare handles
	localparam int OC_W = 32;

	// Configuration port
	localparam int CFG_IDX_W   = 3;
	localparam int STEPS_W     = 5;
	localparam int WIN_LO_RST  = 0;
	localparam int WIN_HI_RST  = 32767;
	localparam int STEPS_RST   = 11;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIN_LEFT     = 3'd0,
		REG_WIN_RIGHT    = 3'd1,
		REG_WIN_TOP      = 3'd2,
		REG_WIN_BOTTOM   = 3'd3,
		REG_BISECT_STEPS = 3'd4
	} reg_idx_t;

	// Window edges, sign extended to the compare width
	typedef struct packed {
		logic signed [OC_W-1:0] left;
		logic signed [OC_W-1:0] right;
		logic signed [OC_W-1:0] top;
		logic signed [OC_W-1:0] bottom;
	} win_t;

	// Per-segment control that travels down the pipeline.
	// Index 0 is the start endpoint, index 1 the end endpoint.
	typedef struct packed {
		logic            reject;
		logic [1:0]      active;
		logic [1:0][3:0] ncode;
	} ctl_t;

	// Outcode: left, right, low y, high y
	function automatic logic [3:0] outcode(input logic signed [OC_W-1:0] x,
		input logic signed [OC_W-1:0] y, input win_t w);
		outcode = {x < w.left, x > w.right, y < w.top, y > w.bottom};
	endfunction

endpackage

`default_nettype wire

/* hdl/mlc_if.sv */
// Channel interfaces of the midpoint line clipper: segment in, result out, config.
// Depends on mlc_pkg for default widths.
`default_nettype none

interface mlc_seg_if import mlc_pkg::*; #(parameter int COORD_BITS = COORD_BITS_DEF);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] start_x;
	logic signed [COORD_BITS-1:0] start_y;
	logic signed [COORD_BITS-1:0] end_x;
	logic signed [COORD_BITS-1:0] end_y;

	modport source(output valid, start_x, start_y, end_x, end_y, input ready);
	modport sink(input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface mlc_clip_if import mlc_pkg::*; #(parameter int COORD_BITS = COORD_BITS_DEF);
	logic                         valid;
	logic                         ready;
	logic                         visible;
	logic signed [COORD_BITS-1:0] clip_start_x;
	logic signed [COORD_BITS-1:0] clip_start_y;
	logic signed [COORD_BITS-1:0] clip_end_x;
	logic signed [COORD_BITS-1:0] clip_end_y;

	modport source(output valid, visible, clip_start_x, clip_start_y, clip_end_x,
		clip_end_y, input ready);
	modport sink(input valid, visible, clip_start_x, clip_start_y, clip_end_x,
		clip_end_y, output ready);
endinterface

interface mlc_cfg_if import mlc_pkg::*; #(parameter int DATA_BITS = COORD_BITS_DEF);
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [DATA_BITS-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

/* hdl/mlc_front.sv */
// Entry stage: endpoint outcodes, trivial reject and search setup.
// Depends on mlc_pkg (outcode, win_t, ctl_t).
`default_nettype none

module mlc_front import mlc_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         load,
	input  logic                         in_valid,
	input  logic signed [COORD_BITS-1:0] in_sx,
	input  logic signed [COORD_BITS-1:0] in_sy,
	input  logic signed [COORD_BITS-1:0] in_ex,
	input  logic signed [COORD_BITS-1:0] in_ey,
	input  win_t                         win,
	output logic                         valid_s1,
	output ctl_t                         ctl_s1,
	output logic [1:0][COORD_BITS-1:0]   near_x_s1,
	output logic [1:0][COORD_BITS-1:0]   near_y_s1,
	output logic [1:0][COORD_BITS-1:0]   far_x_s1,
	output logic [1:0][COORD_BITS-1:0]   far_y_s1
);

	logic [3:0] code_a;
	logic [3:0] code_b;
	ctl_t       ctl_d;

	// Outcodes of both original endpoints
	always_comb begin
		code_a = outcode(OC_W'(in_sx), OC_W'(in_sy), win);
		code_b = outcode(OC_W'(in_ex), OC_W'(in_ey), win);
		ctl_d.reject    = |(code_a & code_b);
		ctl_d.active[0] = (code_a != 4'd0);
		ctl_d.active[1] = (code_b != 4'd0);
		ctl_d.ncode[0]  = code_a;
		ctl_d.ncode[1]  = code_b;
	end

	// Valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= in_valid;
		end
	end

	// Payload: near is the outside endpoint, far the other one.
	// An endpoint already inside keeps itself as far, which is its result.
	always_ff @(posedge clk) begin
		if (load) begin
			ctl_s1       <= ctl_d;
			near_x_s1[0] <= in_sx;
			near_y_s1[0] <= in_sy;
			near_x_s1[1] <= in_ex;
			near_y_s1[1] <= in_ey;
			far_x_s1[0]  <= ctl_d.active[0] ? in_ex : in_sx;
			far_y_s1[0]  <= ctl_d.active[0] ? in_ey : in_sy;
			far_x_s1[1]  <= ctl_d.active[1] ? in_sx : in_ex;
			far_y_s1[1]  <= ctl_d.active[1] ? in_sy : in_ey;
		end
	end

endmodule

`default_nettype wire

/* hdl/mlc_bisect_stage.sv */
// One midpoint bisection step for both endpoints of a segment, registered.
// Depends on mlc_pkg (outcode, win_t, ctl_t).
`default_nettype none

module mlc_bisect_stage import mlc_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int MAX_STEPS  = MAX_STEPS_DEF,
	parameter int STAGE      = 0,
	localparam int SW        = $clog2(MAX_STEPS + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       load,
	input  logic [SW-1:0]              steps,
	input  win_t                       win,
	input  logic                       valid_in,
	input  ctl_t                       ctl_in,
	input  logic [1:0][COORD_BITS-1:0] near_x_in,
	input  logic [1:0][COORD_BITS-1:0] near_y_in,
	input  logic [1:0][COORD_BITS-1:0] far_x_in,
	input  logic [1:0][COORD_BITS-1:0] far_y_in,
	output logic                       valid_sk,
	output ctl_t                       ctl_sk,
	output logic [1:0][COORD_BITS-1:0] near_x_sk,
	output logic [1:0][COORD_BITS-1:0] near_y_sk,
	output logic [1:0][COORD_BITS-1:0] far_x_sk,
	output logic [1:0][COORD_BITS-1:0] far_y_sk
);

	logic                         step_en;
	logic signed [COORD_BITS:0]   sum_x [2];
	logic signed [COORD_BITS:0]   sum_y [2];
	logic [1:0][COORD_BITS-1:0]   mid_x;
	logic [1:0][COORD_BITS-1:0]   mid_y;
	logic [1:0][3:0]              code_m;
	ctl_t                         ctl_d;
	logic [1:0][COORD_BITS-1:0]   near_x_d;
	logic [1:0][COORD_BITS-1:0]   near_y_d;
	logic [1:0][COORD_BITS-1:0]   far_x_d;
	logic [1:0][COORD_BITS-1:0]   far_y_d;

	// Stages past the configured count pass the segment through
	assign step_en = (int'(steps) > STAGE);

	// Floor midpoint and its outcode, then move near or far
	always_comb begin
		ctl_d    = ctl_in;
		near_x_d = near_x_in;
		near_y_d = near_y_in;
		far_x_d  = far_x_in;
		far_y_d  = far_y_in;
		for (int i = 0; i < 2; i++) begin
			sum_x[i]  = (COORD_BITS+1)'(signed'(near_x_in[i]))
				+ (COORD_BITS+1)'(signed'(far_x_in[i]));
			sum_y[i]  = (COORD_BITS+1)'(signed'(near_y_in[i]))
				+ (COORD_BITS+1)'(signed'(far_y_in[i]));
			mid_x[i]  = sum_x[i][COORD_BITS:1];
			mid_y[i]  = sum_y[i][COORD_BITS:1];
			code_m[i] = outcode(OC_W'(signed'(mid_x[i])), OC_W'(signed'(mid_y[i])), win);
			if (step_en && ctl_in.active[i]) begin
				if (code_m[i] == 4'd0) begin
					far_x_d[i] = mid_x[i];
					far_y_d[i] = mid_y[i];
				end else if ((ctl_in.ncode[i] & code_m[i]) != 4'd0) begin
					near_x_d[i]    = mid_x[i];
					near_y_d[i]    = mid_y[i];
					ctl_d.ncode[i] = code_m[i];
				end else begin
					far_x_d[i] = mid_x[i];
					far_y_d[i] = mid_y[i];
				end
			end
		end
	end

	// Valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sk <= 1'b0;
		end else if (load) begin
			valid_sk <= valid_in;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (load) begin
			ctl_sk    <= ctl_d;
			near_x_sk <= near_x_d;
			near_y_sk <= near_y_d;
			far_x_sk  <= far_x_d;
			far_y_sk  <= far_y_d;
		end
	end

endmodule

`default_nettype wire

/* hdl/mlc_back.sv */
// Final stage: visibility check of the searched endpoints and the result register.
// Depends on mlc_pkg (outcode, win_t, ctl_t).
`default_nettype none

module mlc_back import mlc_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  win_t                         win,
	input  logic                         valid_in,
	input  ctl_t                         ctl_in,
	input  logic [1:0][COORD_BITS-1:0]   far_x_in,
	input  logic [1:0][COORD_BITS-1:0]   far_y_in,
	input  logic                         out_ready,
	output logic                         load,
	output logic                         valid_sl,
	output logic                         visible_sl,
	output logic signed [COORD_BITS-1:0] start_x_sl,
	output logic signed [COORD_BITS-1:0] start_y_sl,
	output logic signed [COORD_BITS-1:0] end_x_sl,
	output logic signed [COORD_BITS-1:0] end_y_sl
);

	logic [1:0][3:0] code_f;
	logic            vis;

	// Result register takes a new request when empty or being drained
	assign load = !valid_sl || out_ready;

	// A searched endpoint that is still outside makes the segment invisible
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			code_f[i] = outcode(OC_W'(signed'(far_x_in[i])), OC_W'(signed'(far_y_in[i])), win);
		end
		vis = !ctl_in.reject
			&& !(ctl_in.active[0] && (code_f[0] != 4'd0))
			&& !(ctl_in.active[1] && (code_f[1] != 4'd0));
	end

	// Valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sl <= 1'b0;
		end else if (load) begin
			valid_sl <= valid_in;
		end
	end

	// Result payload, zeroed when invisible
	always_ff @(posedge clk) begin
		if (load) begin
			visible_sl <= vis;
			start_x_sl <= vis ? signed'(far_x_in[0]) : '0;
			start_y_sl <= vis ? signed'(far_y_in[0]) : '0;
			end_x_sl   <= vis ? signed'(far_x_in[1]) : '0;
			end_y_sl   <= vis ? signed'(far_y_in[1]) : '0;
		end
	end

endmodule

`default_nettype wire

/* hdl/midpoint_line_clipper_top.sv */
// Midpoint line clipper: one segment request per cycle while the output is not
// stalled, fully pipelined. Each segment passes an entry stage (outcodes and
// trivial reject), MAX_STEPS bisection stages (one midpoint step for both
// endpoints each) and a result stage, each registered; the unrolled bisection
// stages set the pipeline depth. The configured step count (0 taken as 1,
// capped at MAX_STEPS) only decides which stages act, never the rate. Each
// stage holds its request while the one after it is full and stalled, so idle
// stages still take new requests. Write the window and step registers only
// while no segment is in flight.
// Depends on mlc_pkg, mlc_if, mlc_front, mlc_bisect_stage and mlc_back.
`default_nettype none

module midpoint_line_clipper_top import mlc_pkg::*; #(
	parameter int MAX_STEPS  = MAX_STEPS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	mlc_cfg_if.sink    cfg,
	mlc_seg_if.sink    seg,
	mlc_clip_if.source clip
);

	localparam int SW    = $clog2(MAX_STEPS + 1);
	localparam int WIN_W = (COORD_BITS > 16) ? COORD_BITS : 16;

	logic signed [WIN_W-1:0] win_left_q;
	logic signed [WIN_W-1:0] win_right_q;
	logic signed [WIN_W-1:0] win_top_q;
	logic signed [WIN_W-1:0] win_bottom_q;
	logic [STEPS_W-1:0]      steps_q;
	logic [SW-1:0]           steps_eff;
	win_t                    win;

	// Pipeline wiring: index 0 is the entry stage, k+1 bisection stage k
	logic                       v_p    [MAX_STEPS+1];
	ctl_t                       ctl_p  [MAX_STEPS+1];
	logic [1:0][COORD_BITS-1:0] nx_p   [MAX_STEPS+1];
	logic [1:0][COORD_BITS-1:0] ny_p   [MAX_STEPS+1];
	logic [1:0][COORD_BITS-1:0] fx_p   [MAX_STEPS+1];
	logic [1:0][COORD_BITS-1:0] fy_p   [MAX_STEPS+1];
	logic                       load_c [MAX_STEPS+2];

	// Configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_left_q   <= WIN_W'(WIN_LO_RST);
			win_right_q  <= WIN_W'(WIN_HI_RST);
			win_top_q    <= WIN_W'(WIN_LO_RST);
			win_bottom_q <= WIN_W'(WIN_HI_RST);
			steps_q      <= STEPS_W'(STEPS_RST);
		end else if (cfg.valid) begin
			case (reg_idx_t'(cfg.index))
				REG_WIN_LEFT:     win_left_q   <= WIN_W'(signed'(cfg.data));
				REG_WIN_RIGHT:    win_right_q  <= WIN_W'(signed'(cfg.data));
				REG_WIN_TOP:      win_top_q    <= WIN_W'(signed'(cfg.data));
				REG_WIN_BOTTOM:   win_bottom_q <= WIN_W'(signed'(cfg.data));
				REG_BISECT_STEPS: steps_q      <= cfg.data[STEPS_W-1:0];
				default: ;
			endcase
		end
	end

	// Window for the compares, and the step count limited to the stage count
	always_comb begin
		win.left   = OC_W'(win_left_q);
		win.right  = OC_W'(win_right_q);
		win.top    = OC_W'(win_top_q);
		win.bottom = OC_W'(win_bottom_q);
		if (steps_q == '0) begin
			steps_eff = SW'(1);
		end else if (int'(steps_q) > MAX_STEPS) begin
			steps_eff = SW'(MAX_STEPS);
		end else begin
			steps_eff = SW'(steps_q);
		end
	end

	// Stall chain: a stage loads when it is empty or the next one loads
	assign seg.ready = load_c[0];

	for (genvar k = 0; k <= MAX_STEPS; k++) begin : g_load
		assign load_c[k] = !v_p[k] || load_c[k+1];
	end

	// Entry stage
	mlc_front #(
		.COORD_BITS (COORD_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load_c[0]),
		.in_valid  (seg.valid),
		.in_sx     (seg.start_x),
		.in_sy     (seg.start_y),
		.in_ex     (seg.end_x),
		.in_ey     (seg.end_y),
		.win       (win),
		.valid_s1  (v_p[0]),
		.ctl_s1    (ctl_p[0]),
		.near_x_s1 (nx_p[0]),
		.near_y_s1 (ny_p[0]),
		.far_x_s1  (fx_p[0]),
		.far_y_s1  (fy_p[0])
	);

	// Bisection stages
	for (genvar k = 0; k < MAX_STEPS; k++) begin : g_stage
		mlc_bisect_stage #(
			.COORD_BITS (COORD_BITS),
			.MAX_STEPS  (MAX_STEPS),
			.STAGE      (k)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.load      (load_c[k+1]),
			.steps     (steps_eff),
			.win       (win),
			.valid_in  (v_p[k]),
			.ctl_in    (ctl_p[k]),
			.near_x_in (nx_p[k]),
			.near_y_in (ny_p[k]),
			.far_x_in  (fx_p[k]),
			.far_y_in  (fy_p[k]),
			.valid_sk  (v_p[k+1]),
			.ctl_sk    (ctl_p[k+1]),
			.near_x_sk (nx_p[k+1]),
			.near_y_sk (ny_p[k+1]),
			.far_x_sk  (fx_p[k+1]),
			.far_y_sk  (fy_p[k+1])
		);
	end

	// Result stage
	mlc_back #(
		.COORD_BITS (COORD_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.win        (win),
		.valid_in   (v_p[MAX_STEPS]),
		.ctl_in     (ctl_p[MAX_STEPS]),
		.far_x_in   (fx_p[MAX_STEPS]),
		.far_y_in   (fy_p[MAX_STEPS]),
		.out_ready  (clip.ready),
		.load       (load_c[MAX_STEPS+1]),
		.valid_sl   (clip.valid),
		.visible_sl (clip.visible),
		.start_x_sl (clip.clip_start_x),
		.start_y_sl (clip.clip_start_y),
		.end_x_sl   (clip.clip_end_x),
		.end_y_sl   (clip.clip_end_y)
	);

endmodule

`default_nettype wire

/* hdl/mlc_checker.sv */
// Port-level assertions for the midpoint line clipper, bound to the top level.
// Depends on mlc_pkg and midpoint_line_clipper_top.
`default_nettype none

module mlc_checker import mlc_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  seg_valid,
	input logic                  seg_ready,
	input logic                  clip_valid,
	input logic                  clip_ready,
	input logic                  clip_visible,
	input logic [COORD_BITS-1:0] clip_sx,
	input logic [COORD_BITS-1:0] clip_sy,
	input logic [COORD_BITS-1:0] clip_ex,
	input logic [COORD_BITS-1:0] clip_ey
);

	// An empty result register means every stage can take a request
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!clip_valid |-> seg_ready)
		else $error("segment request refused while the pipeline output is empty");

	// Rejected or invisible segments carry zero coordinates
	a_invisible_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(clip_valid && !clip_visible) |->
		(clip_sx == '0) && (clip_sy == '0) && (clip_ex == '0) && (clip_ey == '0))
		else $error("invisible result with nonzero coordinates");

	// A stalled result holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(clip_valid && !clip_ready) |=> clip_valid && $stable(clip_visible)
		&& $stable(clip_sx) && $stable(clip_sy) && $stable(clip_ex) && $stable(clip_ey))
		else $error("stalled result changed");

	// Inputs seen for completeness of the handshake view
	a_seg_handshake: assert property (@(posedge clk) disable iff (!arst_n)
		(seg_valid && !seg_ready) |-> clip_valid)
		else $error("segment request stalled with an empty output");

endmodule

bind midpoint_line_clipper_top mlc_checker #(
	.COORD_BITS (COORD_BITS)
) u_mlc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.seg_valid    (seg.valid),
	.seg_ready    (seg.ready),
	.clip_valid   (clip.valid),
	.clip_ready   (clip.ready),
	.clip_visible (clip.visible),
	.clip_sx      (clip.clip_start_x),
	.clip_sy      (clip.clip_start_y),
	.clip_ex      (clip.clip_end_x),
	.clip_ey      (clip.clip_end_y)
);

`default_nettype wire
